// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the queue and back-end RTL files of the math unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on the rising clock, off while reset is high.
`define SCAU_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Overlapping implication, checked on the rising clock, off while reset is high.
`define SCAU_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) else $error(msg);

`endif

// File: hw/rtl/scau_pkg.sv
// Shared types, codes and constants of the sqrt / cos / acos unit.
`default_nettype none

package scau_pkg;

  // Defaults for the top-level parameters
  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Request codes on req_type
  localparam logic [1:0] REQ_SQRT = 2'd0;
  localparam logic [1:0] REQ_COS  = 2'd1;
  localparam logic [1:0] REQ_ACOS = 2'd2;
  localparam logic [1:0] REQ_NONE = 2'd3;   // unused code, answers zero

  // Operation class after decode; OP_ZERO covers the unused code
  typedef enum logic [1:0] {
    OP_SQRT = 2'd0,
    OP_COS  = 2'd1,
    OP_ACOS = 2'd2,
    OP_ZERO = 2'd3
  } op_t;

  // Decoded command passed from the front end to the back end
  typedef struct packed {
    op_t         op;
    logic        neg;   // acos: operand was negative
    logic [31:0] rad;   // root input (integer part of the radicand)
    logic [31:0] mag;   // cos: |x|, acos: |clamped x|
  } cmd_t;

  // Constants with 30 fraction bits
  localparam logic [63:0] Q30_C0      = 64'd20110433;
  localparam logic [63:0] Q30_C1      = 64'd79737142;
  localparam logic [63:0] Q30_C2      = 64'd227756103;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam logic [63:0] Q30_PI      = 64'd3373259426;
  localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;

  // Round a Q30 constant to f fraction bits, half up
  function automatic logic [63:0] to_frac(input logic [63:0] c30, input int f);
    int s;
    logic [63:0] r;
    s = 30 - f;
    if (s == 0) begin
      r = c30;
    end else begin
      r = (c30 + (64'd1 << (s - 1))) >> s;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/scau_front.sv
// Front end: request decode, operand clamp and radicand select.
`default_nettype none

module scau_front #(
  parameter int FRAC_BITS = scau_pkg::FRAC_BITS_DEF
) (
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire logic [1:0]         req_type,
  input  wire logic signed [31:0] operand,
  output logic                    push_valid,
  output scau_pkg::cmd_t          push_cmd,
  input  wire logic               push_ready
);

  localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

  logic        is_neg;
  logic [31:0] abs_x;
  logic [31:0] acos_a;

  // Beat passes straight into the queue
  assign req_ready  = push_ready;
  assign push_valid = req_valid;

  assign is_neg = operand[31];
  assign abs_x  = is_neg ? 32'(-operand) : 32'(operand);

  // |x| clamped to one
  assign acos_a = (abs_x > ONE) ? ONE : abs_x;

  // Decode
  always_comb begin
    push_cmd.neg = is_neg;
    push_cmd.rad = '0;
    push_cmd.mag = abs_x;
    case (req_type)
      scau_pkg::REQ_SQRT: begin
        push_cmd.op  = scau_pkg::OP_SQRT;
        push_cmd.rad = is_neg ? 32'd0 : 32'(operand);
      end
      scau_pkg::REQ_COS: begin
        push_cmd.op  = scau_pkg::OP_COS;
      end
      scau_pkg::REQ_ACOS: begin
        push_cmd.op  = scau_pkg::OP_ACOS;
        push_cmd.rad = ONE - acos_a;
        push_cmd.mag = acos_a;
      end
      default: begin
        push_cmd.op  = scau_pkg::OP_ZERO;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/scau_queue.sv
// Command queue between the front end and the back end.
`default_nettype none
`include "assert_macros.svh"

module scau_queue #(
  parameter int DEPTH = scau_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  input  wire scau_pkg::cmd_t push_cmd,
  output logic                push_ready,
  output logic                pop_valid,
  output scau_pkg::cmd_t      pop_cmd,
  input  wire logic           pop_ready
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  scau_pkg::cmd_t mem [0:DEPTH-1];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;
  logic           pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `SCAU_ASSERT(a_count_max, clk, rst, count <= CW'(DEPTH), "queue count beyond depth")
  `SCAU_ASSERT(a_count_inc, clk, rst, (push && !pop) |=> (count == $past(count) + 1'b1), "queue count did not grow on push")

endmodule

`default_nettype wire

// File: hw/rtl/scau_back.sv
// Back end: pipelined root / angle reduction, then polynomial and output stages.
`default_nettype none
`include "assert_macros.svh"

module scau_back #(
  parameter int FRAC_BITS = scau_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  input  wire scau_pkg::cmd_t     q_cmd,
  output logic                    q_ready,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output logic signed [31:0]      result
);

  localparam int F    = FRAC_BITS;
  localparam int SW   = (32 + F) / 2;          // root bits
  localparam int RADW = 2 * SW;                // radicand bits
  localparam int RMW  = SW + 2;                // partial remainder bits
  localparam int QB   = (F < 29) ? (29 - F) : 0; // reduction steps
  localparam int NA   = (SW > QB) ? SW : QB;   // iterative stages
  localparam int UW   = F + 2;
  localparam int W2   = F + 4;
  localparam int W4   = F + 7;
  localparam int W6   = F + 10;
  localparam int W8   = F + 14;
  localparam int AW   = F + 1;
  localparam int TW   = F + 2;
  localparam int SUMW = F + 6;
  localparam int FW   = (F + 6 > 34) ? (F + 6) : 34;
  localparam int NV   = NA + 8;

  localparam logic [63:0] PI_L     = scau_pkg::to_frac(scau_pkg::Q30_PI, F);
  localparam logic [63:0] TWO_PI_L = scau_pkg::to_frac(scau_pkg::Q30_TWO_PI, F);
  localparam logic [63:0] HP_L     = scau_pkg::to_frac(scau_pkg::Q30_HALF_PI, F);
  localparam logic [63:0] C0_L     = scau_pkg::to_frac(scau_pkg::Q30_C0, F);
  localparam logic [63:0] C1_L     = scau_pkg::to_frac(scau_pkg::Q30_C1, F);
  localparam logic [63:0] C2_L     = scau_pkg::to_frac(scau_pkg::Q30_C2, F);
  localparam logic [TW-1:0] PI_T   = PI_L[TW-1:0];
  localparam logic [TW-1:0] HP_T   = HP_L[TW-1:0];
  localparam logic [TW-1:0] C0_T   = C0_L[TW-1:0];
  localparam logic [TW-1:0] C1_T   = C1_L[TW-1:0];
  localparam logic [TW-1:0] C2_T   = C2_L[TW-1:0];
  localparam logic [32:0]   TWO_PI_33 = TWO_PI_L[32:0];
  localparam logic [SW-1:0] ROOT_MAX  = SW'(64'd1 << F);
  localparam logic [SUMW-1:0] ONE_S   = SUMW'(64'd1 << F);

  // Reciprocals of the Taylor divisors, rounded up
  localparam int S4 = W4 + 5;
  localparam int S6 = W6 + 10;
  localparam int S8 = W8 + 16;
  localparam logic [63:0] M4_L = ((64'd1 << S4) + 64'd23) / 64'd24;
  localparam logic [63:0] M6_L = ((64'd1 << S6) + 64'd719) / 64'd720;
  localparam logic [63:0] M8_L = ((64'd1 << S8) + 64'd40319) / 64'd40320;
  localparam logic [W4:0] M4_T = M4_L[W4:0];
  localparam logic [W6:0] M6_T = M6_L[W6:0];
  localparam logic [W8:0] M8_T = M8_L[W8:0];

  logic          adv;
  logic [NV-1:0] vld;

  // Iterative stage registers
  scau_pkg::op_t a_op   [0:NA];
  logic          a_neg  [0:NA];
  logic [RADW-1:0] a_rad [0:NA];
  logic [RMW-1:0]  a_rem [0:NA];
  logic [SW-1:0]   a_root [0:NA];
  logic [31:0]     a_mrem [0:NA];
  logic [AW-1:0]   a_aval [0:NA];

  // Polynomial stage registers
  scau_pkg::op_t b0_op, b1_op, b2_op, b3_op, b4_op, b5_op;
  logic          b0_neg, b1_neg, b2_neg, b3_neg, b4_neg;
  logic [SW-1:0] b0_root, b1_root, b2_root, b3_root, b4_root;
  logic [AW-1:0] b0_aval, b1_aval, b2_aval;
  logic [UW-1:0] b0_u;
  logic [W2-1:0] b1_x2, b2_x2, b3_x2, b4_x2, b5_x2;
  logic [W4-1:0] b2_x4, b3_d4, b4_d4, b5_d4;
  logic [W6-1:0] b3_x6, b4_d6, b5_d6;
  logic [W8-1:0] b4_x8, b5_d8;
  logic [TW-1:0] b1_t1, b2_t2, b3_t3, b4_t4;
  logic [FW-1:0] b5_val;

  // Whole pipeline moves unless the output beat is held
  assign adv       = !rsp_valid || rsp_ready;
  assign q_ready   = adv;
  assign rsp_valid = vld[NV-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NV-2:0], q_valid};
    end
  end

  // Stage load from the queue
  always_ff @(posedge clk) begin
    if (adv) begin
      a_op[0]   <= q_cmd.op;
      a_neg[0]  <= q_cmd.neg;
      a_rad[0]  <= RADW'({q_cmd.rad, {F{1'b0}}});
      a_rem[0]  <= '0;
      a_root[0] <= '0;
      a_mrem[0] <= q_cmd.mag;
      a_aval[0] <= AW'(q_cmd.mag);
    end
  end

  // One root digit per stage for the first SW stages, one reduction step per stage for the first QB
  genvar i;
  for (i = 0; i < NA; i++) begin : g_a
    logic [RMW-1:0] rem_n;
    logic [SW-1:0]  root_n;
    logic [31:0]    mrem_n;

    if (i < SW) begin : g_sq
      logic [SW+3:0] rem_sh;
      logic [SW+3:0] trial;
      logic          take;
      assign rem_sh = {a_rem[i], a_rad[i][RADW-1-2*i -: 2]};
      assign trial  = (SW+4)'({a_root[i], 2'b01});
      assign take   = (rem_sh >= trial);
      assign rem_n  = take ? RMW'(rem_sh - trial) : RMW'(rem_sh);
      assign root_n = {a_root[i][SW-2:0], take};
    end else begin : g_sq_pass
      assign rem_n  = a_rem[i];
      assign root_n = a_root[i];
    end

    if (i < QB) begin : g_md
      localparam logic [63:0] CK = TWO_PI_L << (QB - 1 - i);
      assign mrem_n = (64'(a_mrem[i]) >= CK) ? (a_mrem[i] - CK[31:0]) : a_mrem[i];
    end else begin : g_md_pass
      assign mrem_n = a_mrem[i];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        a_op[i+1]   <= a_op[i];
        a_neg[i+1]  <= a_neg[i];
        a_rad[i+1]  <= a_rad[i];
        a_rem[i+1]  <= rem_n;
        a_root[i+1] <= root_n;
        a_mrem[i+1] <= mrem_n;
        a_aval[i+1] <= a_aval[i];
      end
    end
  end

  // Products
  logic [2*UW-1:0]    px2;
  logic [2*W2-1:0]    px4;
  logic [W4+W2-1:0]   px6;
  logic [W6+W2-1:0]   px8;
  logic [2*W4:0]      pd4;
  logic [2*W6:0]      pd6;
  logic [2*W8:0]      pd8;
  logic [TW+AW-1:0]   pt1, pt2, pt3;
  logic [TW+SW-1:0]   pt4;
  logic [SUMW-1:0]    cos_sum;
  logic [FW-1:0]      fv;
  logic [FW-32:0]     fv_hi;

  assign px2 = (2*UW)'(b0_u) * (2*UW)'(b0_u);
  assign pt1 = (TW+AW)'(C0_T) * (TW+AW)'(b0_aval);
  assign px4 = (2*W2)'(b1_x2) * (2*W2)'(b1_x2);
  assign pt2 = (TW+AW)'(b1_t1) * (TW+AW)'(b1_aval);
  assign px6 = (W4+W2)'(b2_x4) * (W4+W2)'(b2_x2);
  assign pd4 = (2*W4+1)'(b2_x4) * (2*W4+1)'(M4_T);
  assign pt3 = (TW+AW)'(b2_t2) * (TW+AW)'(b2_aval);
  assign px8 = (W6+W2)'(b3_x6) * (W6+W2)'(b3_x2);
  assign pd6 = (2*W6+1)'(b3_x6) * (2*W6+1)'(M6_T);
  assign pt4 = (TW+SW)'(b3_t3) * (TW+SW)'(b3_root);
  assign pd8 = (2*W8+1)'(b4_x8) * (2*W8+1)'(M8_T);

  // Taylor sum and saturation
  assign cos_sum = ONE_S - SUMW'(b5_x2 >> 1) + SUMW'(b5_d4) - SUMW'(b5_d6) + SUMW'(b5_d8);
  assign fv      = (b5_op == scau_pkg::OP_COS) ? FW'($signed(cos_sum)) : b5_val;
  assign fv_hi   = fv[FW-1:31];

  always_ff @(posedge clk) begin
    if (adv) begin
      // B0: fold remainder into [0, pi]
      b0_op   <= a_op[NA];
      b0_neg  <= a_neg[NA];
      b0_root <= a_root[NA];
      b0_aval <= a_aval[NA];
      b0_u    <= (64'(a_mrem[NA]) > PI_L) ? UW'(TWO_PI_L - 64'(a_mrem[NA]))
                                          : UW'(a_mrem[NA]);
      // B1: x^2, first Horner step
      b1_op   <= b0_op;
      b1_neg  <= b0_neg;
      b1_root <= b0_root;
      b1_aval <= b0_aval;
      b1_x2   <= px2[F +: W2];
      b1_t1   <= C1_T - TW'(pt1 >> F);
      // B2: x^4, second Horner step
      b2_op   <= b1_op;
      b2_neg  <= b1_neg;
      b2_root <= b1_root;
      b2_aval <= b1_aval;
      b2_x2   <= b1_x2;
      b2_x4   <= px4[F +: W4];
      b2_t2   <= C2_T - TW'(pt2 >> F);
      // B3: x^6, x^4/24, third Horner step
      b3_op   <= b2_op;
      b3_neg  <= b2_neg;
      b3_root <= b2_root;
      b3_x2   <= b2_x2;
      b3_x6   <= px6[F +: W6];
      b3_d4   <= W4'(pd4 >> S4);
      b3_t3   <= HP_T - TW'(pt3 >> F);
      // B4: x^8, x^6/720, times the root
      b4_op   <= b3_op;
      b4_neg  <= b3_neg;
      b4_root <= b3_root;
      b4_x2   <= b3_x2;
      b4_d4   <= b3_d4;
      b4_x8   <= px8[F +: W8];
      b4_d6   <= W6'(pd6 >> S6);
      b4_t4   <= TW'(pt4 >> F);
      // B5: x^8/40320, select root, angle or zero
      b5_op   <= b4_op;
      b5_x2   <= b4_x2;
      b5_d4   <= b4_d4;
      b5_d6   <= b4_d6;
      b5_d8   <= W8'(pd8 >> S8);
      case (b4_op)
        scau_pkg::OP_SQRT: b5_val <= FW'(b4_root);
        scau_pkg::OP_ACOS: b5_val <= b4_neg ? FW'(PI_T - b4_t4) : FW'(b4_t4);
        default:           b5_val <= '0;
      endcase
      // B6: output register
      if (!fv[FW-1] && (|fv_hi)) begin
        result <= 32'sh7FFF_FFFF;
      end else if (fv[FW-1] && !(&fv_hi)) begin
        result <= 32'sh8000_0000;
      end else begin
        result <= signed'(fv[31:0]);
      end
    end
  end

  `SCAU_ASSERT(a_stall_hold, clk, rst, !adv |=> $stable(vld), "pipeline moved while output held")
  `SCAU_ASSERT_IMP(a_acos_root, clk, rst, vld[NA] && (a_op[NA] == scau_pkg::OP_ACOS), a_root[NA] <= ROOT_MAX, "acos root above one")
  `SCAU_ASSERT_IMP(a_cos_reduced, clk, rst, vld[NA] && (a_op[NA] == scau_pkg::OP_COS), 33'(a_mrem[NA]) < TWO_PI_33, "angle not reduced below two pi")

endmodule

`default_nettype wire

// File: hw/rtl/sqrt_cos_acos_unit.sv
// Path: request decode, command queue, then the digit-per-stage root and angle reduction
// pipeline and the polynomial and output stages.
// Throughput: one beat per cycle while the result side is not stalled; a command queue
// of QUEUE_DEPTH entries (4 by default) lets requests enter while results are stalled.
// Reset: synchronous, clears the queue and all pipeline valid bits; data paths keep state.
`default_nettype none

module sqrt_cos_acos_unit #(
  parameter int FRAC_BITS   = scau_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = scau_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire logic [1:0]         req_type,
  input  wire logic signed [31:0] operand,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output logic signed [31:0]      result
);

  logic           push_valid;
  logic           push_ready;
  scau_pkg::cmd_t push_cmd;
  logic           pop_valid;
  logic           pop_ready;
  scau_pkg::cmd_t pop_cmd;

  // Decode
  scau_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_type   (req_type),
    .operand    (operand),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  // Decoupling queue
  scau_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  // Arithmetic pipeline
  scau_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (pop_valid),
    .q_cmd     (pop_cmd),
    .q_ready   (pop_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .result    (result)
  );

endmodule

`default_nettype wire
